// ===== src/fls_pkg.sv =====
// ----------------------------------------------------------------------------
// fls_pkg: shared definitions for the flux limiter select block
// Word widths, limiter selection codes, register map constants and the
// control bundle that drives the pipelined divider.
// ----------------------------------------------------------------------------
package fls_pkg;

  // Working width of the divider operands. The largest dividend is
  // r^2 + r*ONE with r below 2^31, which stays below 2^63.
  localparam int DW = 64;

  // Configuration register.
  localparam int SEL_W  = 3;
  localparam int ADDR_W = 3;

  localparam logic [SEL_W-1:0] SEL_MINMOD    = 3'd1;
  localparam logic [SEL_W-1:0] SEL_VANALBADA = 3'd2;
  localparam logic [SEL_W-1:0] SEL_VANLEER   = 3'd3;
  localparam logic [SEL_W-1:0] SEL_SUPERBEE  = 3'd4;
  localparam logic [SEL_W-1:0] SEL_MC        = 3'd5;
  localparam logic [SEL_W-1:0] SEL_RESET     = SEL_MINMOD;

  // Register index, taken from the word-aligned part of paddr.
  localparam logic REG_IDX_SELECT = 1'b0;

  // Stage control handed to the divider: the shared advance enable and the
  // valid bit of the request entering it.
  typedef struct packed {
    logic en;
    logic valid;
  } pipe_ctl_t;

endpackage

// ===== src/fls_div_pipe.sv =====
// ----------------------------------------------------------------------------
// fls_div_pipe: pipelined restoring divider
// Returns floor(num * 2^FRAC_BITS / den) for num below 2*den, one quotient
// bit per stage, with side data travelling alongside.
// ----------------------------------------------------------------------------
module fls_div_pipe #(
  parameter int FRAC_BITS = 16,
  parameter int SIDE_W    = 1
) (
  input  logic                    clk,
  input  logic                    rst,
  input  fls_pkg::pipe_ctl_t      ctl,
  input  logic [fls_pkg::DW-1:0]  num,
  input  logic [fls_pkg::DW-1:0]  den,
  input  logic [SIDE_W-1:0]       side_in,
  output logic                    out_valid,
  output logic [FRAC_BITS+1:0]    quot,
  output logic [SIDE_W-1:0]       side_out
);

  localparam int QW = FRAC_BITS + 2;

  logic                   v   [FRAC_BITS+1];
  logic [fls_pkg::DW-1:0] rem [FRAC_BITS+1];
  logic [fls_pkg::DW-1:0] dd  [FRAC_BITS+1];
  logic [QW-1:0]          q   [FRAC_BITS+1];
  logic [SIDE_W-1:0]      sd  [FRAC_BITS+1];

  // The integer part of the quotient is a single bit, so the first stage is
  // one compare and subtract.
  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (ctl.en) begin
      v[0] <= ctl.valid;
    end
    if (ctl.en) begin
      if (num >= den) begin
        rem[0] <= num - den;
        q[0]   <= QW'(1);
      end else begin
        rem[0] <= num;
        q[0]   <= '0;
      end
      dd[0] <= den;
      sd[0] <= side_in;
    end
  end

  for (genvar k = 1; k <= FRAC_BITS; k++) begin : g_bit
    logic [fls_pkg::DW-1:0] shifted;
    logic                   fits;

    // The remainder stays below den < 2^63, so the doubled value fits.
    assign shifted = rem[k-1] << 1;
    assign fits    = (shifted >= dd[k-1]);

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (ctl.en) begin
        v[k] <= v[k-1];
      end
      if (ctl.en) begin
        rem[k] <= fits ? (shifted - dd[k-1]) : shifted;
        q[k]   <= {q[k-1][QW-2:0], fits};
        dd[k]  <= dd[k-1];
        sd[k]  <= sd[k-1];
      end
    end
  end

  assign out_valid = v[FRAC_BITS];
  assign quot      = q[FRAC_BITS];
  assign side_out  = sd[FRAC_BITS];

endmodule

// ===== src/flux_limiter_select.sv =====
// ----------------------------------------------------------------------------
// flux_limiter_select: TVD flux limiter with a selectable law
// Maps a signed slope ratio r to the limiter value phi(r) for minmod,
// van Albada, van Leer, superbee or monotonized central.
// ----------------------------------------------------------------------------
// Throughput: one request per cycle while no result waits untaken in the
//   output register; the depth is set by the divider, which resolves one
//   quotient bit per pipeline stage.
// Reset: synchronous, clears every valid bit and sets limiter_select to
//   minmod.
// ----------------------------------------------------------------------------
module flux_limiter_select #(
  parameter  int FRAC_BITS = 16,
  localparam int OUT_W     = FRAC_BITS + 2,
  localparam int TDATA_W   = ((OUT_W + 7) / 8) * 8
) (
  input  logic                       clk,
  input  logic                       rst,
  // Input requests.
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [31:0]                s_axis_tdata,   // [31:0] ratio
  // Results.
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [TDATA_W-1:0]         m_axis_tdata,   // [OUT_W-1:0] limited
  // Configuration port.
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [fls_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  localparam int DW = fls_pkg::DW;

  // Fixed-point constants at the working widths used below.
  localparam logic [32:0]    ONE33  = 33'(1) << FRAC_BITS;
  localparam logic [32:0]    TWO33  = 33'(2) << FRAC_BITS;
  localparam logic [DW-1:0]  ONE_D  = DW'(1) << FRAC_BITS;
  localparam logic [DW-1:0]  ONE_SQ = DW'(1) << (2 * FRAC_BITS);
  localparam logic [OUT_W-1:0] TWO_O = OUT_W'(2) << FRAC_BITS;

  // --------------------------------------------------------------------------
  // Configuration register. The register index is the word address, so the
  // low two bits of paddr are ignored. Writes to other words are dropped.
  // --------------------------------------------------------------------------
  logic [fls_pkg::SEL_W-1:0] limiter_select;
  logic                      cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      limiter_select <= fls_pkg::SEL_RESET;
    end else if (cfg_write && paddr[2] == fls_pkg::REG_IDX_SELECT) begin
      limiter_select <= pwdata[fls_pkg::SEL_W-1:0];
    end
  end

  always_comb begin
    if (paddr[2] == fls_pkg::REG_IDX_SELECT) begin
      prdata = {{(32 - fls_pkg::SEL_W){1'b0}}, limiter_select};
    end else begin
      prdata = '0;
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline advance. The whole pipeline moves together and only stops when
  // the output register holds a result that the consumer has not taken yet.
  // A request is therefore accepted in every cycle in which the output
  // register is empty or is being drained.
  // --------------------------------------------------------------------------
  logic en;

  assign en            = ~m_axis_tvalid | m_axis_tready;
  assign s_axis_tready = en;

  // --------------------------------------------------------------------------
  // Stage 0: register the request. Only a strictly positive ratio gives a
  // non-zero result, so the sign and zero tests are made once here and the
  // ratio is carried on as a 31-bit magnitude.
  // --------------------------------------------------------------------------
  logic                      v0;
  logic                      pos0;
  logic [30:0]               r0;
  logic [fls_pkg::SEL_W-1:0] sel0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= s_axis_tvalid;
    end
    if (en) begin
      pos0 <= ~s_axis_tdata[31] & (s_axis_tdata[30:0] != '0);
      r0   <= s_axis_tdata[30:0];
      sel0 <= limiter_select;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: square the ratio for van Albada, and evaluate the laws that
  // need no division (minmod, superbee, monotonized central) directly with
  // a few compares. Each of those is bounded by 2.0 by construction.
  // --------------------------------------------------------------------------
  logic [32:0]      r33;
  logic [32:0]      two_r;
  logic [32:0]      half_sum;
  logic [32:0]      mm_val;
  logic [32:0]      sb_lo;
  logic [32:0]      sb_hi;
  logic [32:0]      mc_lo;
  logic [32:0]      direct_wide;
  logic [OUT_W-1:0] direct_next;
  logic             va_next;
  logic             vl_next;
  logic [61:0]      sq_next;

  always_comb begin
    r33      = {2'b00, r0};
    two_r    = {1'b0, r0, 1'b0};
    half_sum = (ONE33 + r33) >> 1;
    mm_val   = (r33 < ONE33) ? r33 : ONE33;
    sb_lo    = (two_r < ONE33) ? two_r : ONE33;
    sb_hi    = (r33 < TWO33) ? r33 : TWO33;
    mc_lo    = (two_r < half_sum) ? two_r : half_sum;

    case (sel0)
      fls_pkg::SEL_MINMOD:   direct_wide = mm_val;
      fls_pkg::SEL_SUPERBEE: direct_wide = (sb_lo > sb_hi) ? sb_lo : sb_hi;
      fls_pkg::SEL_MC:       direct_wide = (mc_lo < TWO33) ? mc_lo : TWO33;
      default:               direct_wide = '0;
    endcase

    direct_next = pos0 ? direct_wide[OUT_W-1:0] : '0;
    va_next     = pos0 & (sel0 == fls_pkg::SEL_VANALBADA);
    vl_next     = pos0 & (sel0 == fls_pkg::SEL_VANLEER);
    sq_next     = 62'(r0) * 62'(r0);
  end

  logic             v1;
  logic [30:0]      r1;
  logic [61:0]      sq1;
  logic [OUT_W-1:0] direct1;
  logic             va1;
  logic             vl1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= v0;
    end
    if (en) begin
      r1      <= r0;
      sq1     <= sq_next;
      direct1 <= direct_next;
      va1     <= va_next;
      vl1     <= vl_next;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: form the dividend and divisor, both scaled so that the divider
  // only has to append FRAC_BITS fraction bits.
  //   van Albada: (r^2 + r*ONE) / (r^2 + ONE^2)
  //   van Leer:   (2r) / (r + ONE)
  // Other laws send a harmless 0 / 1 and take their value from the side data.
  // --------------------------------------------------------------------------
  logic [DW-1:0] num_next;
  logic [DW-1:0] den_next;

  always_comb begin
    if (va1) begin
      num_next = DW'(sq1) + (DW'(r1) << FRAC_BITS);
      den_next = DW'(sq1) + ONE_SQ;
    end else if (vl1) begin
      num_next = DW'(r1) << 1;
      den_next = DW'(r1) + ONE_D;
    end else begin
      num_next = '0;
      den_next = DW'(1);
    end
  end

  logic             v2;
  logic [DW-1:0]    num2;
  logic [DW-1:0]    den2;
  logic [OUT_W:0]   side2;   // {use quotient, direct value}

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
    if (en) begin
      num2  <= num_next;
      den2  <= den_next;
      side2 <= {va1 | vl1, direct1};
    end
  end

  // --------------------------------------------------------------------------
  // Divider: FRAC_BITS + 1 stages, one quotient bit each.
  // --------------------------------------------------------------------------
  fls_pkg::pipe_ctl_t div_ctl;
  logic               dv_valid;
  logic [OUT_W-1:0]   dv_quot;
  logic [OUT_W:0]     dv_side;

  assign div_ctl.en    = en;
  assign div_ctl.valid = v2;

  fls_div_pipe #(
    .FRAC_BITS (FRAC_BITS),
    .SIDE_W    (OUT_W + 1)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .ctl       (div_ctl),
    .num       (num2),
    .den       (den2),
    .side_in   (side2),
    .out_valid (dv_valid),
    .quot      (dv_quot),
    .side_out  (dv_side)
  );

  // --------------------------------------------------------------------------
  // Output register: pick the quotient or the direct value, and clamp to 2.0
  // as a final guard.
  // --------------------------------------------------------------------------
  logic [OUT_W-1:0] pick;
  logic [OUT_W-1:0] res_next;
  logic [OUT_W-1:0] res;

  always_comb begin
    pick     = dv_side[OUT_W] ? dv_quot : dv_side[OUT_W-1:0];
    res_next = (pick > TWO_O) ? TWO_O : pick;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= dv_valid;
    end
    if (en) begin
      res <= res_next;
    end
  end

  assign m_axis_tdata = TDATA_W'(res);

endmodule

// ===== sim/flux_limiter_check.sv =====
// ----------------------------------------------------------------------------
// flux_limiter_check: result checker for the flux limiter select block
// Follows the configuration port to keep its own copy of the limiter
// selection. Predicts phi(r) for every accepted ratio request and compares
// each accepted result, in order, with the oldest prediction.
// ----------------------------------------------------------------------------
module flux_limiter_check #(
  parameter  int FRAC_BITS = 16,
  localparam int OUT_W     = FRAC_BITS + 2,
  localparam int TDATA_W   = ((OUT_W + 7) / 8) * 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_axis_tvalid,
  input  logic                       s_axis_tready,
  input  logic [31:0]                s_axis_tdata,   // [31:0] ratio
  input  logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  input  logic [TDATA_W-1:0]         m_axis_tdata,   // [OUT_W-1:0] limited
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [fls_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  input  logic [31:0]                prdata,
  input  logic                       pready,
  output int                         fail_count,
  output int                         outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SEL_W  = fls_pkg::SEL_W;
  localparam int ADDR_W = fls_pkg::ADDR_W;

  localparam logic [63:0] ONE = 64'd1 << FRAC_BITS;
  localparam logic [63:0] TWO = 64'd2 << FRAC_BITS;

  typedef struct packed {
    logic [31:0]      ratio;
    logic [SEL_W-1:0] law;
    logic [OUT_W-1:0] limited;
  } face_t;

  face_t            face_q[$];
  logic [SEL_W-1:0] law;

  function automatic logic [63:0] min64(logic [63:0] a, logic [63:0] b);
    return (a < b) ? a : b;
  endfunction

  // floor(num * ONE / den), with room for the shifted dividend.
  function automatic logic [63:0] scaled_div(logic [63:0] num, logic [63:0] den);
    logic [127:0] q;
    q = ({64'd0, num} << FRAC_BITS) / {64'd0, den};
    return q[63:0];
  endfunction

  function automatic logic [OUT_W-1:0] limiter_value(logic [31:0] ratio,
                                                     logic [SEL_W-1:0] sel);
    logic [63:0] r;
    logic [63:0] sq;
    logic [63:0] phi;
    r   = {32'd0, ratio};
    sq  = r * r;
    phi = '0;
    // Only a strictly positive ratio gives a nonzero limiter value.
    if (ratio != 32'd0 && !ratio[31]) begin
      case (sel)
        fls_pkg::SEL_MINMOD:    phi = min64(r, ONE);
        fls_pkg::SEL_VANALBADA: phi = scaled_div(sq + (r << FRAC_BITS),
                                                 sq + (64'd1 << (2 * FRAC_BITS)));
        fls_pkg::SEL_VANLEER:   phi = scaled_div(r << 1, r + ONE);
        fls_pkg::SEL_SUPERBEE: begin
          phi = min64(r << 1, ONE);
          if (min64(r, TWO) > phi) begin
            phi = min64(r, TWO);
          end
        end
        fls_pkg::SEL_MC:        phi = min64(min64(r << 1, (ONE + r) >> 1), TWO);
        default:                phi = '0;
      endcase
      phi = min64(phi, TWO);
    end
    return phi[OUT_W-1:0];
  endfunction

  always @(posedge clk) begin : monitor
    face_t face;
    int    fails;
    bit    reg_hit;
    fails   = fail_count;
    reg_hit = (paddr[ADDR_W-1:2] == fls_pkg::REG_IDX_SELECT);
    if (rst) begin
      law         <= fls_pkg::SEL_RESET;
      fail_count  <= 0;
      outstanding <= 0;
      face_q.delete();
    end else begin
      if (psel && penable && pwrite && pready && reg_hit) begin
        law <= pwdata[SEL_W-1:0];
      end
      if (psel && penable && !pwrite && pready && reg_hit) begin
        if (prdata !== {{(32 - SEL_W){1'b0}}, law}) begin
          if (fails < 10) begin
            $display("mismatch: register read expected %0d, got %h", law, prdata);
          end
          fails++;
        end
      end
      // Results are retired before new requests are queued, so a result
      // cannot be matched against a request taken on the same edge.
      if (m_axis_tvalid && m_axis_tready) begin
        if (face_q.size() == 0) begin
          if (fails < 10) begin
            $display("mismatch: result %h with no request outstanding", m_axis_tdata);
          end
          fails++;
        end else begin
          face = face_q.pop_front();
          if (m_axis_tdata !== TDATA_W'(face.limited)) begin
            if (fails < 10) begin
              $display("mismatch: ratio %h law %0d expected %h, got %h",
                       face.ratio, face.law, face.limited, m_axis_tdata);
            end
            fails++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        face.ratio   = s_axis_tdata;
        face.law     = law;
        face.limited = limiter_value(s_axis_tdata, law);
        face_q.push_back(face);
      end
      fail_count  <= fails;
      outstanding <= face_q.size();
    end
  end

endmodule

// ===== sim/tb_flux_limiter_select.sv =====
// ----------------------------------------------------------------------------
// tb_flux_limiter_select: testbench for the flux limiter select block
// Drives slope ratio requests and limiter selections through the stream and
// configuration ports with random gaps and back-pressure; a separate checker
// predicts and compares every result and reports its failure count here.
// ----------------------------------------------------------------------------
module tb_flux_limiter_select;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SEL_W     = fls_pkg::SEL_W;
  localparam int ADDR_W    = fls_pkg::ADDR_W;
  localparam int FRAC_BITS = 16;
  localparam int OUT_W     = FRAC_BITS + 2;
  localparam int TDATA_W   = ((OUT_W + 7) / 8) * 8;

  // Fixed-point landmarks used to aim the stimulus at the limiter knees.
  localparam logic [31:0] ONE = 32'd1 << FRAC_BITS;
  localparam logic [31:0] TWO = 32'd2 << FRAC_BITS;

  // Selection codes that choose no limiter at all.
  localparam logic [SEL_W-1:0] SEL_OFF_ZERO  = 3'd0;
  localparam logic [SEL_W-1:0] SEL_OFF_SIX   = 3'd6;
  localparam logic [SEL_W-1:0] SEL_OFF_SEVEN = 3'd7;

  // Register map: the selection register and the unused slot after it.
  localparam logic [ADDR_W-1:0] REG_ADDR_SELECT = 3'd0;
  localparam logic [ADDR_W-1:0] REG_ADDR_SPARE  = 3'd4;

  localparam int N_CORNERS    = 16;
  localparam int N_PHASES     = 11;
  localparam int PHASE_ITEMS  = 150;
  localparam int PRESSURE_AT  = 300;
  localparam int HOLD_OFF     = 400;
  localparam int DRAIN_CYCLES = FRAC_BITS + 5 + 20;
  localparam int CYCLE_LIMIT  = 1000000;

  logic               clk           = 1'b0;
  logic               rst           = 1'b1;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [31:0]        s_axis_tdata  = '0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [TDATA_W-1:0] m_axis_tdata;
  logic               psel          = 1'b0;
  logic               penable       = 1'b0;
  logic               pwrite        = 1'b0;
  logic [ADDR_W-1:0]  paddr         = '0;
  logic [31:0]        pwdata        = '0;
  logic [31:0]        prdata;
  logic               pready;

  int fail_count;
  int outstanding;
  int n_sent   = 0;
  bit draining = 1'b0;

  flux_limiter_select #(
    .FRAC_BITS(FRAC_BITS)
  ) uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  flux_limiter_check #(
    .FRAC_BITS(FRAC_BITS)
  ) checker_i (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .fail_count    (fail_count),
    .outstanding   (outstanding)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Ratios at the edges of the input range and at every knee of the five
  // laws: r = 1/3 and r = 3 for monotonized central, 1/2, 1 and 2 for
  // superbee and minmod, plus zero and the negative extremes.
  function automatic logic [31:0] corner_ratio(int k);
    case (k)
      0:       return 32'd0;
      1:       return 32'd1;
      2:       return ONE / 3;
      3:       return (ONE >> 1) - 1;
      4:       return ONE >> 1;
      5:       return ONE - 1;
      6:       return ONE;
      7:       return ONE + 1;
      8:       return TWO - 1;
      9:       return TWO;
      10:      return TWO + 1;
      11:      return 3 * ONE;
      12:      return 3 * ONE + 1;
      13:      return 32'h7FFF_FFFF;
      14:      return 32'h8000_0000;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  // Seven in sixteen ratios are positive and moderate, where the laws differ;
  // the rest: corners, near-knee values, negatives, raw words of either sign.
  function automatic logic [31:0] random_ratio();
    int unsigned pick;
    pick = $urandom_range(0, 15);
    if (pick < 2) begin
      return corner_ratio($urandom_range(0, N_CORNERS - 1));
    end else if (pick < 4) begin
      return corner_ratio($urandom_range(2, 12)) + $urandom_range(0, 16) - 8;
    end else if (pick < 6) begin
      return $urandom | 32'h8000_0000;
    end else if (pick < 7) begin
      return $urandom;
    end else if (pick < 9) begin
      return $urandom & 32'h7FFF_FFFF;
    end else if (pick < 13) begin
      return $urandom_range(1, 4 * ONE);
    end else begin
      return $urandom_range(1, 64 * ONE);
    end
  endfunction

  // Offers one ratio request and returns at the rising edge that accepted
  // it, with tvalid still high. The ready flag is looked at on the falling
  // edge, where every output has settled, so the handshake is race free.
  // In a burst the requests follow back to back; otherwise most of them do
  // too and the rest come after a random gap, now and then a long one.
  task automatic send_ratio(input logic [31:0] ratio, input bit burst);
    int unsigned pick;
    int gap;
    pick = $urandom_range(0, 99);
    if (burst || pick < 70) begin
      gap = 0;
    end else if (pick < 95) begin
      gap = $urandom_range(1, 3);
    end else begin
      gap = $urandom_range(10, 40);
    end
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ratio;
    @(negedge clk);
    while (!s_axis_tready) @(negedge clk);
    @(posedge clk);
    n_sent++;
  endtask

  // Stops offering and waits until every predicted result has been taken,
  // returning on a rising edge.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // One configuration access: a setup cycle, then an access cycle held
  // until pready, then psel low and an idle bus before returning, so that
  // back-to-back calls never drive psel twice on the same edge.
  task automatic apb_access(input logic write, input logic [ADDR_W-1:0] addr,
                            input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    while (!pready) @(negedge clk);
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Receiver: alternates stretches of readiness with short and long stalls,
  // holds off once for a long stretch to fill the pipeline and stall the
  // input, and stays ready while the run drains.
  initial begin : receiver
    bit held;
    int unsigned pick;
    held = 1'b0;
    @(posedge clk);
    forever begin
      pick = $urandom_range(0, 19);
      if (draining) begin
        m_axis_tready <= 1'b1;
        @(posedge clk);
      end else if (!held && n_sent >= PRESSURE_AT) begin
        held = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_OFF) @(posedge clk);
      end else if (pick < 12) begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end else if (pick < 19) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(10, 60)) @(posedge clk);
      end
    end
  end

  // Sender and verdict.
  initial begin : stimulus
    logic [SEL_W-1:0] law;
    bit burst;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed pass under the reset selection (minmod): every corner ratio.
    for (int k = 0; k < N_CORNERS; k++) begin
      send_ratio(corner_ratio(k), 1'b0);
    end

    // Random phases, each under its own selection. Every law and every
    // unused code, the lowest and highest among them, get a phase; the last
    // few pick a selection at random. The upper bits of the written word
    // are noise that the register must drop.
    for (int p = 0; p < N_PHASES; p++) begin
      case (p)
        0:       law = fls_pkg::SEL_VANALBADA;
        1:       law = fls_pkg::SEL_VANLEER;
        2:       law = fls_pkg::SEL_SUPERBEE;
        3:       law = fls_pkg::SEL_MC;
        4:       law = SEL_OFF_ZERO;
        5:       law = fls_pkg::SEL_MINMOD;
        6:       law = SEL_OFF_SEVEN;
        7:       law = SEL_OFF_SIX;
        default: law = SEL_W'($urandom);
      endcase
      wait_idle();
      apb_access(1'b1, REG_ADDR_SELECT, {$urandom} & ~32'(SEL_W'('1)) | 32'(law));
      // A write to the unused slot must leave the selection untouched.
      if (p == 0 || $urandom_range(0, 2) == 0) begin
        apb_access(1'b1, REG_ADDR_SPARE, $urandom);
      end
      apb_access(1'b0, REG_ADDR_SELECT, '0);
      burst = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        send_ratio(random_ratio(), burst);
      end
    end

    // Let every result arrive, then watch for strays over the pipeline depth.
    draining = 1'b1;
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Timeout: far beyond the slowest correct run.
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAILURE");
    $finish;
  end

endmodule
